// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the allocator design; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// implication or plain property, sampled on clk, off during reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold, off during reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)

`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ===== design/rbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// rbpa_pkg
// Types and codes of the reference-counted block pool allocator.
// ----------------------------------------------------------------------------
package rbpa_pkg;

    // field widths of the command, result and configuration beats
    localparam int MODE_W   = 2;
    localparam int BLOCK_W  = 10;
    localparam int STATUS_W = 2;
    localparam int REFCNT_W = 16;
    localparam int CFG_W    = 11;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD_REF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd2;

    // configuration register indexes
    localparam logic CFG_MAX_BLOCKS  = 1'b0;
    localparam logic CFG_SLAB_BLOCKS = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [BLOCK_W-1:0] block_index;
    } cmd_t;

    typedef struct packed {
        logic [BLOCK_W-1:0]  granted_index;
        logic [STATUS_W-1:0] status;
        logic                became_free;
        logic [REFCNT_W-1:0] ref_count;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROW,
        ST_POP,
        ST_REF
    } state_t;

endpackage

// ===== design/rbpa_ram.sv =====
// ----------------------------------------------------------------------------
// rbpa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rbpa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/refcounted_block_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// refcounted_block_pool_allocator
// Block pool allocator with a LIFO free stack and per-block reference counts.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; its result comes
// back as a single-cycle done strobe with the result beat and cannot be held
// off, so the receiver must take it in that cycle. Add reference, release and
// acquire from a non-empty free stack first do a registered read of the count
// or stack RAM, then the modify, write back and result; no new beat is taken
// until the sequencer is back in idle. An acquire that finds the stack empty
// first grows the pool, writing one fresh block per cycle into both RAMs,
// then pops as above, or reports exhausted when nothing can be grown.
// Both RAMs start undefined and need no clearing pass: only entries below the
// stack depth and counts of grown blocks are ever used. Configuration writes
// are always ready and should be issued only while no command is in flight.
module refcounted_block_pool_allocator
    import rbpa_pkg::*;
#(
    parameter int POOL_CAPACITY = 1024,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    output logic             done,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(POOL_CAPACITY);
    localparam int DW    = IDX_W + 1;
    localparam int LW    = (DW > CFG_W) ? DW : CFG_W;

    localparam logic [DW-1:0]          CAP_D     = DW'(POOL_CAPACITY);
    localparam logic [LW-1:0]          CAP_L     = LW'(POOL_CAPACITY);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    state_t               state_reg, state_next;
    logic [DW-1:0]        depth_reg, depth_next;
    logic [DW-1:0]        grown_reg, grown_next;
    logic [DW-1:0]        left_reg, left_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [BLOCK_W-1:0]   idx_reg, idx_next;
    logic [CFG_W-1:0]     max_blocks_reg;
    logic [CFG_W-1:0]     slab_reg;
    logic                 done_reg, done_next;
    result_t              result_reg, result_next;

    logic                   stk_we, stk_re;
    logic [IDX_W-1:0]       stk_waddr, stk_raddr;
    logic [IDX_W-1:0]       stk_wdata, stk_rdata;
    logic                   cnt_we, cnt_re;
    logic [IDX_W-1:0]       cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;

    logic                    accept;
    logic [DW-1:0]           depth_m1;
    logic [LW-1:0]           max_ext, slab_ext, grown_ext, limit, room, slab_n, grow_n;
    logic [LW+BLOCK_W-1:0]   reg_idx_wide;
    logic [IDX_W+BLOCK_W-1:0] cmd_addr_wide, reg_addr_wide, blk_wide;
    logic                    is_grown;
    logic [COUNT_WIDTH-1:0]  cur_cnt, cnt_inc, cnt_dec;
    logic [COUNT_WIDTH+REFCNT_W-1:0] cur_wide, inc_wide, dec_wide;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_blocks_reg <= '0;
            slab_reg       <= CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_BLOCKS:  max_blocks_reg <= cfg_data;
                CFG_SLAB_BLOCKS: slab_reg       <= cfg_data;
                default:         max_blocks_reg <= max_blocks_reg;
            endcase
        end
    end

    // growth size: slab (zero read as one) clamped to the room left under the block limit
    always_comb
    begin
        max_ext   = LW'(max_blocks_reg);
        slab_ext  = LW'(slab_reg);
        grown_ext = LW'(grown_reg);
        limit     = (max_ext == '0 || max_ext > CAP_L) ? CAP_L : max_ext;
        slab_n    = (slab_ext == '0) ? LW'(1) : slab_ext;
        room      = (grown_ext >= limit) ? '0 : (limit - grown_ext);
        grow_n    = (slab_n > room) ? room : slab_n;
    end

    // index widening and addressing
    always_comb
    begin
        depth_m1      = depth_reg - 1'b1;
        reg_idx_wide  = {{LW{1'b0}}, idx_reg};
        cmd_addr_wide = {{IDX_W{1'b0}}, cmd.block_index};
        reg_addr_wide = {{IDX_W{1'b0}}, idx_reg};
        blk_wide      = {{BLOCK_W{1'b0}}, stk_rdata};
        is_grown      = (reg_idx_wide[LW-1:0] < grown_ext);
        cur_cnt       = is_grown ? cnt_rdata : '0;
        cnt_inc       = cur_cnt + 1'b1;
        cnt_dec       = cur_cnt - 1'b1;
        cur_wide      = {{REFCNT_W{1'b0}}, cur_cnt};
        inc_wide      = {{REFCNT_W{1'b0}}, cnt_inc};
        dec_wide      = {{REFCNT_W{1'b0}}, cnt_dec};
    end

    // control state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            depth_reg <= '0;
            grown_reg <= '0;
            left_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            grown_reg <= grown_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
        end
    end

    // captured command and result beat
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        idx_reg    <= idx_next;
        result_reg <= result_next;
    end

    // sequencer: next state, RAM accesses and result
    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        grown_next  = grown_reg;
        left_next   = left_reg;
        mode_next   = mode_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        stk_re    = 1'b0;
        stk_raddr = depth_m1[IDX_W-1:0];
        stk_we    = 1'b0;
        stk_waddr = depth_reg[IDX_W-1:0];
        stk_wdata = grown_reg[IDX_W-1:0];
        cnt_re    = 1'b0;
        cnt_raddr = cmd_addr_wide[IDX_W-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = grown_reg[IDX_W-1:0];
        cnt_wdata = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = cmd.mode;
                    idx_next  = cmd.block_index;
                    if (cmd.mode == MODE_ACQUIRE)
                    begin
                        if (depth_reg == '0)
                        begin
                            left_next  = grow_n[DW-1:0];
                            state_next = ST_GROW;
                        end
                        else
                        begin
                            stk_re     = 1'b1;
                            state_next = ST_POP;
                        end
                    end
                    else
                    begin
                        cnt_re     = 1'b1;
                        state_next = ST_REF;
                    end
                end
            end

            ST_GROW:
            begin
                if (left_reg != '0)
                begin
                    // push one fresh block with count zero
                    stk_we     = 1'b1;
                    cnt_we     = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    grown_next = grown_reg + 1'b1;
                    left_next  = left_reg - 1'b1;
                end
                else if (depth_reg == '0)
                begin
                    done_next                 = 1'b1;
                    result_next.granted_index = '0;
                    result_next.status        = STATUS_EXHAUSTED;
                    result_next.became_free   = 1'b0;
                    result_next.ref_count     = '0;
                    state_next                = ST_IDLE;
                end
                else
                begin
                    stk_re     = 1'b1;
                    state_next = ST_POP;
                end
            end

            ST_POP:
            begin
                // top of stack is out of the RAM: hand it out with count one
                cnt_we                    = 1'b1;
                cnt_waddr                 = stk_rdata;
                cnt_wdata                 = COUNT_ONE;
                depth_next                = depth_m1;
                done_next                 = 1'b1;
                result_next.granted_index = blk_wide[BLOCK_W-1:0];
                result_next.status        = STATUS_OK;
                result_next.became_free   = 1'b0;
                result_next.ref_count     = REFCNT_W'(1);
                state_next                = ST_IDLE;
            end

            ST_REF:
            begin
                done_next                 = 1'b1;
                state_next                = ST_IDLE;
                cnt_waddr                 = reg_addr_wide[IDX_W-1:0];
                stk_wdata                 = reg_addr_wide[IDX_W-1:0];
                result_next.granted_index = idx_reg;
                result_next.became_free   = 1'b0;
                result_next.status        = STATUS_INVALID;
                result_next.ref_count     = cur_wide[REFCNT_W-1:0];
                priority if ((mode_reg != MODE_ADD_REF && mode_reg != MODE_RELEASE)
                             || !is_grown || cur_cnt == '0)
                begin
                    result_next.status = STATUS_INVALID;
                end
                else if (mode_reg == MODE_ADD_REF)
                begin
                    if (cur_cnt != COUNT_MAX)
                    begin
                        cnt_we                = 1'b1;
                        cnt_wdata             = cnt_inc;
                        result_next.status    = STATUS_OK;
                        result_next.ref_count = inc_wide[REFCNT_W-1:0];
                    end
                end
                else
                begin
                    cnt_we                = 1'b1;
                    cnt_wdata             = cnt_dec;
                    result_next.status    = STATUS_OK;
                    result_next.ref_count = dec_wide[REFCNT_W-1:0];
                    if (cnt_dec == '0)
                    begin
                        // last reference gone: back on the free stack
                        result_next.became_free = 1'b1;
                        if (depth_reg < CAP_D)
                        begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // free stack of block numbers
    rbpa_ram #(
        .DEPTH (POOL_CAPACITY),
        .WIDTH (IDX_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // reference count per block
    rbpa_ram #(
        .DEPTH (POOL_CAPACITY),
        .WIDTH (COUNT_WIDTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

`include "assert_macros.svh"

    // a result always lands with the sequencer back in idle
    `ASSERT_PROP(a_done_idle, done |-> !busy, "result strobe while busy")
    // an accepted command always makes the sequencer busy in the next cycle
    `ASSERT_PROP(a_accept_busy, accept |=> busy, "accepted command did not go busy")
    // free blocks never outnumber blocks grown so far
    `ASSERT_NEVER(a_depth_grown, depth_reg > grown_reg, "free stack deeper than pool")
    // exhausted acquire reports an empty grant
    `ASSERT_PROP(a_exhausted_empty,
        (done && result.status == STATUS_EXHAUSTED) |->
        (result.granted_index == '0 && result.ref_count == '0 && depth_reg == '0),
        "exhausted result with nonempty fields")

endmodule

// ===== verif/tb_refcounted_block_pool_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_refcounted_block_pool_allocator
// Self-checking bench for the block pool allocator: command beats go out in
// random bursts and gaps, a behavioral copy of the free stack, the reference
// counts and the growth rules predicts every result beat, and a checker
// compares each done strobe against the oldest prediction. Edge cases,
// count updates and several pool limit / slab size settings are covered.
// ----------------------------------------------------------------------------
module tb_refcounted_block_pool_allocator;
    import rbpa_pkg::*;

    localparam int               POOL_BLOCKS  = 1024;
    localparam int               COUNT_BITS   = 16;
    localparam logic [REFCNT_W-1:0] COUNT_TOP = {REFCNT_W{1'b1}};
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int               CYCLE_LIMIT  = 1000000;
    localparam int               TAIL_CYCLES  = 16;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cmd_t             cmd;
    logic             done;
    result_t          result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // shadow copy of the allocator bookkeeping
    logic [BLOCK_W-1:0]  free_blocks [POOL_BLOCKS];
    int                  free_depth;
    logic [REFCNT_W-1:0] block_refs [POOL_BLOCKS];
    int                  blocks_grown;
    logic [CFG_W-1:0]    pool_max_blocks;
    logic [CFG_W-1:0]    pool_slab_blocks;
    logic [BLOCK_W-1:0]  held_blocks [$];

    result_t pool_replies [$];
    result_t last_reply;
    bit      mismatch_seen;
    int      burst_left;
    int      cycle_count;

    refcounted_block_pool_allocator #(
        .POOL_CAPACITY(POOL_BLOCKS),
        .COUNT_WIDTH  (COUNT_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[refcounted_block_pool_allocator] ERROR");
            $finish;
        end
    end

    // outcome of one operation on the shadow pool, state updated in place
    function automatic result_t apply_pool_op(input cmd_t c);
        result_t             r;
        logic                known;
        logic [REFCNT_W-1:0] cnt;
        logic [BLOCK_W-1:0]  blk;
        int                  lim;
        int                  n;
        known = int'(c.block_index) < blocks_grown;
        cnt   = known ? block_refs[c.block_index] : '0;
        r.granted_index = c.block_index;
        r.status        = STATUS_INVALID;
        r.became_free   = 1'b0;
        r.ref_count     = cnt;
        case (c.mode)
            MODE_ACQUIRE:
            begin
                // grow the pool by one slab when the stack runs dry
                if (free_depth == 0)
                begin
                    lim = (pool_max_blocks == 0 || pool_max_blocks > POOL_BLOCKS) ?
                          POOL_BLOCKS : int'(pool_max_blocks);
                    n   = (pool_slab_blocks == 0) ? 1 : int'(pool_slab_blocks);
                    if (blocks_grown < lim)
                    begin
                        if (n > lim - blocks_grown)
                            n = lim - blocks_grown;
                        for (int i = 0; i < n; i++)
                        begin
                            block_refs[BLOCK_W'(blocks_grown + i)] = '0;
                            if (free_depth < POOL_BLOCKS)
                            begin
                                free_blocks[BLOCK_W'(free_depth)] =
                                    BLOCK_W'(blocks_grown + i);
                                free_depth++;
                            end
                        end
                        blocks_grown += n;
                    end
                end
                if (free_depth == 0)
                begin
                    r.granted_index = '0;
                    r.status        = STATUS_EXHAUSTED;
                    r.ref_count     = '0;
                end
                else
                begin
                    free_depth--;
                    blk             = free_blocks[BLOCK_W'(free_depth)];
                    block_refs[blk] = REFCNT_W'(1);
                    held_blocks.insert(held_blocks.size(), blk);
                    r.granted_index = blk;
                    r.status        = STATUS_OK;
                    r.ref_count     = REFCNT_W'(1);
                end
            end
            MODE_ADD_REF:
            begin
                if (known && cnt != 0 && cnt != COUNT_TOP)
                begin
                    cnt                        = cnt + 1'b1;
                    block_refs[c.block_index] = cnt;
                    r.status                   = STATUS_OK;
                    r.ref_count                = cnt;
                end
            end
            MODE_RELEASE:
            begin
                if (known && cnt != 0)
                begin
                    cnt                        = cnt - 1'b1;
                    block_refs[c.block_index] = cnt;
                    r.status                   = STATUS_OK;
                    r.ref_count                = cnt;
                    // last reference gone: block goes back on the stack
                    if (cnt == 0)
                    begin
                        r.became_free = 1'b1;
                        if (free_depth < POOL_BLOCKS)
                        begin
                            free_blocks[BLOCK_W'(free_depth)] = c.block_index;
                            free_depth++;
                        end
                        for (int k = 0; k < held_blocks.size(); k++)
                        begin
                            if (held_blocks[k] == c.block_index)
                            begin
                                held_blocks.delete(k);
                                break;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // result checker, one beat per done strobe
    always @(posedge clk)
    begin : check_replies
        result_t want;
        if (rst_n && done)
        begin
            if (pool_replies.size() == 0)
            begin
                $error("result beat with no command outstanding: %p", result);
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = pool_replies.pop_front();
                if (result.granted_index !== want.granted_index)
                begin
                    $error("granted_index: expected %0d, got %0d",
                           want.granted_index, result.granted_index);
                    mismatch_seen = 1'b1;
                end
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatch_seen = 1'b1;
                end
                if (result.became_free !== want.became_free)
                begin
                    $error("became_free: expected %0d, got %0d",
                           want.became_free, result.became_free);
                    mismatch_seen = 1'b1;
                end
                if (result.ref_count !== want.ref_count)
                begin
                    $error("ref_count: expected %0d, got %0d", want.ref_count, result.ref_count);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // one command beat, entered and left at a falling edge
    task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [BLOCK_W-1:0] b);
        // bursts of random length with random gaps in between
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(99) < 70)
                repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start           = 1'b1;
        cmd.mode        = m;
        cmd.block_index = b;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
            @(negedge clk);
        end
        last_reply = apply_pool_op(cmd);
        pool_replies.insert(pool_replies.size(), last_reply);
        burst_left--;
        @(negedge clk);
        start = 1'b0;
    endtask

    // wait until every result is back and the block has settled
    task automatic drain_replies;
        while (pool_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // one register write beat
    task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        if (idx == CFG_MAX_BLOCKS)
            pool_max_blocks = value;
        else
            pool_slab_blocks = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] max_v, input logic [CFG_W-1:0] slab_v);
        drain_replies();
        write_cfg(CFG_MAX_BLOCKS, max_v);
        write_cfg(CFG_SLAB_BLOCKS, slab_v);
    endtask

    // mostly well-formed acquire / add / release traffic on live blocks, some noise
    task automatic run_random(input int n_items, input int acquire_pct, input int noise_pct);
        int                 roll;
        logic [MODE_W-1:0]  m;
        logic [BLOCK_W-1:0] b;
        repeat (n_items)
        begin
            roll = $urandom_range(99);
            b    = BLOCK_W'($urandom);
            if (roll < acquire_pct)
                m = MODE_ACQUIRE;
            else if (roll < acquire_pct + noise_pct || held_blocks.size() == 0)
            begin
                m = MODE_W'($urandom_range(MODE_UNUSED, MODE_ACQUIRE));
                if (blocks_grown > 0 && $urandom_range(1) == 1)
                    b = BLOCK_W'($urandom_range(blocks_grown - 1));
            end
            else
            begin
                b = held_blocks[$urandom_range(held_blocks.size() - 1)];
                m = ($urandom_range(99) < 40) ? MODE_ADD_REF : MODE_RELEASE;
            end
            send_cmd(m, b);
        end
    endtask

    // tiny pool, unit slabs: exhaustion, free / ungrown / unused-mode cases
    task automatic test_edge_cases;
        configure(11'd4, 11'd0);
        send_cmd(MODE_ACQUIRE, 10'd0);
        send_cmd(MODE_ACQUIRE, 10'd1023);
        send_cmd(MODE_ACQUIRE, 10'd0);
        send_cmd(MODE_ACQUIRE, 10'd1023);
        send_cmd(MODE_ACQUIRE, 10'd0);
        send_cmd(MODE_ADD_REF, 10'd0);
        send_cmd(MODE_RELEASE, 10'd0);
        send_cmd(MODE_RELEASE, 10'd0);
        send_cmd(MODE_RELEASE, 10'd0);
        send_cmd(MODE_ADD_REF, 10'd0);
        send_cmd(MODE_ADD_REF, 10'd1023);
        send_cmd(MODE_RELEASE, 10'd1023);
        send_cmd(MODE_UNUSED, 10'd1);
        send_cmd(MODE_UNUSED, 10'd1023);
        send_cmd(MODE_ACQUIRE, 10'd1023);
        send_cmd(MODE_RELEASE, 10'd1);
        send_cmd(MODE_RELEASE, 10'd2);
        send_cmd(MODE_RELEASE, 10'd3);
        send_cmd(MODE_RELEASE, 10'd0);
    endtask

    // raise one block's count a few times, drop it to free, then touch it again
    task automatic test_ref_counting;
        logic [BLOCK_W-1:0] blk;
        send_cmd(MODE_ACQUIRE, 10'd0);
        blk = last_reply.granted_index;
        repeat (3)
            send_cmd(MODE_ADD_REF, blk);
        repeat (4)
            send_cmd(MODE_RELEASE, blk);
        send_cmd(MODE_RELEASE, blk);
        send_cmd(MODE_ADD_REF, blk);
    endtask

    // pool of 40 grown three at a time, acquire heavy so it runs out
    task automatic test_slab_growth;
        configure(11'd40, 11'd3);
        run_random(200, 55, 15);
    endtask

    // limit dropped below what is already grown: no more growth
    task automatic test_lowered_limit;
        configure(11'd1, 11'd2047);
        run_random(100, 60, 15);
    endtask

    // limit and slab size at full capacity: rest of the pool grows in one slab
    task automatic test_full_pool_growth;
        configure(11'd1024, 11'd1024);
        run_random(150, 50, 15);
    endtask

    // limit above capacity, fewer acquires
    task automatic test_oversized_limit;
        configure(11'd2047, 11'd1);
        run_random(100, 35, 20);
    endtask

    // limit back to its zero default
    task automatic test_default_limit;
        configure(11'd0, 11'd1);
        run_random(50, 40, 20);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        cmd              = '0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_MAX_BLOCKS;
        cfg_data         = '0;
        free_depth       = 0;
        blocks_grown     = 0;
        pool_max_blocks  = '0;
        pool_slab_blocks = 11'd1;
        mismatch_seen    = 1'b0;
        burst_left       = 0;
        cycle_count      = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_edge_cases();
        test_ref_counting();
        test_slab_growth();
        test_lowered_limit();
        test_full_pool_growth();
        test_oversized_limit();
        test_default_limit();

        drain_replies();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (!mismatch_seen && pool_replies.size() == 0)
            $display("[refcounted_block_pool_allocator] OK");
        else
            $display("[refcounted_block_pool_allocator] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/rbpa_pkg.sv
design/rbpa_ram.sv
design/refcounted_block_pool_allocator.sv
verif/tb_refcounted_block_pool_allocator.sv
